// File: sv/substring_match_scanner_unit_assert.svh
// Assertion macros used by the substring match scanner match stage
`ifndef SUBSTRING_MATCH_SCANNER_UNIT_ASSERT_SVH
`define SUBSTRING_MATCH_SCANNER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Antecedent holds -> consequent holds in the same cycle
`define SMS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");
// Antecedent holds -> consequent holds in the next cycle
`define SMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define SMS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SMS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: sv/sms_pkg.sv
// Shared constants, types and helper functions of the substring match scanner
package sms_pkg;

  // Defaults for the top-level parameters
  localparam int SMS_MAX_PATTERN   = 16;
  localparam int SMS_POSITION_BITS = 32;

  // Fixed field widths
  localparam int NEEDLE_BYTES  = 16;
  localparam int LEN_BITS      = 5;
  localparam int OUT_BITS      = 32;
  localparam int WIDE_BITS     = 64;
  localparam int CFG_ADDR_BITS = 5;
  localparam int CFG_DATA_BITS = 64;

  // Register map, one 64-bit register every 8 bytes
  typedef enum logic [1:0] {
    REG_PATTERN_LOW    = 2'd0,
    REG_PATTERN_HIGH   = 2'd1,
    REG_PATTERN_LENGTH = 2'd2
  } sms_reg_t;

  // Configuration handed from the register block to the datapath
  typedef struct packed {
    logic [WIDE_BITS-1:0] pattern_low;
    logic [WIDE_BITS-1:0] pattern_high;
    logic [LEN_BITS-1:0]  pattern_length;
  } sms_cfg_t;

  // Control of the item held between the window and match stages
  typedef struct packed {
    logic valid;
    logic final_byte;
  } sms_stage_t;

  // Clamp a wide value to the 32-bit result fields
  function automatic logic [OUT_BITS-1:0] sat_out(input logic [WIDE_BITS-1:0] v);
    sat_out = (|v[WIDE_BITS-1:OUT_BITS]) ? '1 : v[OUT_BITS-1:0];
  endfunction

  // Needle length in use: limited by the needle store and the window depth
  function automatic logic [LEN_BITS-1:0] eff_length(input logic [LEN_BITS-1:0] raw,
                                                     input int max_pattern);
    int lim;
    lim = (max_pattern < NEEDLE_BYTES) ? max_pattern : NEEDLE_BYTES;
    eff_length = (int'(raw) > lim) ? LEN_BITS'(lim) : raw;
  endfunction

endpackage

// File: sv/sms_if.sv
// Valid/ready channel interfaces for haystack bytes and scan results
interface sms_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

interface sms_out_if;
  logic        valid;
  logic        ready;
  logic        match_found;
  logic [31:0] first_position;
  logic [31:0] last_position;
  logic [31:0] occurrence_count;
  logic [31:0] text_length;

  modport source (output valid, output match_found, output first_position,
                  output last_position, output occurrence_count, output text_length,
                  input ready);
  modport sink   (input valid, input match_found, input first_position,
                  input last_position, input occurrence_count, input text_length,
                  output ready);
endinterface

// File: sv/sms_cfg_regs.sv
// APB-style register block holding the needle and its length
module sms_cfg_regs
  import sms_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output sms_cfg_t                 cfg
);

  logic [WIDE_BITS-1:0] pattern_low_r;
  logic [WIDE_BITS-1:0] pattern_high_r;
  logic [LEN_BITS-1:0]  pattern_length_r;
  logic                 wr_en;
  sms_reg_t             reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = sms_reg_t'(paddr[CFG_ADDR_BITS-1:3]);

  // Register writes on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_low_r    <= '0;
      pattern_high_r   <= '0;
      pattern_length_r <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_PATTERN_LOW:    pattern_low_r    <= pwdata;
        REG_PATTERN_HIGH:   pattern_high_r   <= pwdata;
        REG_PATTERN_LENGTH: pattern_length_r <= pwdata[LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read-back mux
  always_comb begin
    unique case (reg_sel)
      REG_PATTERN_LOW:    prdata = pattern_low_r;
      REG_PATTERN_HIGH:   prdata = pattern_high_r;
      REG_PATTERN_LENGTH: prdata = CFG_DATA_BITS'(pattern_length_r);
      default:            prdata = '0;
    endcase
  end

  assign cfg.pattern_low    = pattern_low_r;
  assign cfg.pattern_high   = pattern_high_r;
  assign cfg.pattern_length = pattern_length_r;

endmodule

// File: sv/sms_window.sv
// Input stage: byte window shift, position count and the input register
module sms_window
  import sms_pkg::*;
#(
  parameter int MAX_PATTERN   = SMS_MAX_PATTERN,
  parameter int POSITION_BITS = SMS_POSITION_BITS,
  localparam int WIN = (MAX_PATTERN < NEEDLE_BYTES) ? MAX_PATTERN : NEEDLE_BYTES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  sms_in_if.sink                        in_ch,
  input  logic                          adv,
  output sms_stage_t                    s1_ctl,
  output logic [WIN-1:0][7:0]           s1_win,
  output logic [POSITION_BITS-1:0]      s1_idx,
  output logic [POSITION_BITS-1:0]      s1_pos
);

  logic [WIN-1:0][7:0]        win_r;
  logic [WIN-1:0][7:0]        shifted;
  logic [POSITION_BITS-1:0]   pos_r;
  logic [POSITION_BITS-1:0]   pos_inc;
  logic                       s1_valid_r;
  logic                       s1_final_r;
  logic [WIN-1:0][7:0]        s1_win_r;
  logic [POSITION_BITS-1:0]   s1_idx_r;
  logic [POSITION_BITS-1:0]   s1_pos_r;
  logic                       accept;

  // Stage register frees up when empty or when its item moves on
  assign in_ch.ready = !s1_valid_r || adv;
  assign accept      = in_ch.valid && in_ch.ready;

  // Newest byte enters at entry 0
  always_comb begin
    shifted[0] = in_ch.text_byte;
    for (int k = 1; k < WIN; k++) begin
      shifted[k] = win_r[k-1];
    end
  end

  // Saturating byte index
  assign pos_inc = (pos_r == '1) ? pos_r : pos_r + 1'b1;

  // Scan state: window and position restart after the last byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      win_r      <= '0;
      pos_r      <= '0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
      win_r      <= in_ch.final_byte ? '0 : shifted;
      pos_r      <= in_ch.final_byte ? '0 : pos_inc;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Item payload for the match stage
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_final_r <= in_ch.final_byte;
      s1_win_r   <= shifted;
      s1_idx_r   <= pos_r;
      s1_pos_r   <= pos_inc;
    end
  end

  assign s1_ctl.valid      = s1_valid_r;
  assign s1_ctl.final_byte = s1_final_r;
  assign s1_win            = s1_win_r;
  assign s1_idx            = s1_idx_r;
  assign s1_pos            = s1_pos_r;

endmodule

// File: sv/sms_match.sv
// Match stage: window compare, match statistics and the result register
`include "substring_match_scanner_unit_assert.svh"

module sms_match
  import sms_pkg::*;
#(
  parameter int MAX_PATTERN   = SMS_MAX_PATTERN,
  parameter int POSITION_BITS = SMS_POSITION_BITS,
  localparam int WIN = (MAX_PATTERN < NEEDLE_BYTES) ? MAX_PATTERN : NEEDLE_BYTES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sms_cfg_t                      cfg,
  input  sms_stage_t                    s1_ctl,
  input  logic [WIN-1:0][7:0]           s1_win,
  input  logic [POSITION_BITS-1:0]      s1_idx,
  input  logic [POSITION_BITS-1:0]      s1_pos,
  output logic                          adv,
  sms_out_if.source                     out_ch
);

  logic [NEEDLE_BYTES-1:0][7:0] needle;
  logic [LEN_BITS-1:0]          len;
  logic [LEN_BITS-1:0]          len_m1;
  logic [WIN-1:0]               byte_ok;
  logic [LEN_BITS-1:0]          nidx [WIN];
  logic                         hit;
  logic [POSITION_BITS-1:0]     start;

  logic                         seen_r, seen_nxt;
  logic [POSITION_BITS-1:0]     first_r, first_nxt;
  logic [POSITION_BITS-1:0]     last_r, last_nxt;
  logic [OUT_BITS-1:0]          count_r, count_nxt;
  logic [LEN_BITS-1:0]          skip_r, skip_nxt;

  logic                         out_valid_r;
  logic                         found_r;
  logic [OUT_BITS-1:0]          first_pos_r;
  logic [OUT_BITS-1:0]          last_pos_r;
  logic [OUT_BITS-1:0]          occ_r;
  logic [OUT_BITS-1:0]          text_len_r;
  logic                         flush;

  assign needle = {cfg.pattern_high, cfg.pattern_low};
  assign len    = eff_length(cfg.pattern_length, MAX_PATTERN);
  assign len_m1 = len - 1'b1;

  // Item moves on unless it carries a result and the result register is full and not taken
  assign adv   = s1_ctl.valid && (!s1_ctl.final_byte || !out_valid_r || out_ch.ready);
  assign flush = adv && s1_ctl.final_byte;

  // Window entry w holds needle byte len-1-w; entries past the length are ignored
  always_comb begin
    for (int w = 0; w < WIN; w++) begin
      nidx[w]    = len_m1 - LEN_BITS'(w);
      byte_ok[w] = (LEN_BITS'(w) >= len) || (s1_win[w] == needle[nidx[w][3:0]]);
    end
  end

  assign hit   = (len != '0) && (s1_idx >= POSITION_BITS'(len_m1)) && (&byte_ok);
  assign start = s1_idx - POSITION_BITS'(len_m1);

  // Statistics update for this byte
  always_comb begin
    seen_nxt  = seen_r || hit;
    first_nxt = (hit && !seen_r) ? start : first_r;
    last_nxt  = hit ? start : last_r;
    count_nxt = count_r;
    skip_nxt  = skip_r;
    if (skip_r != '0) begin
      skip_nxt = skip_r - 1'b1;
    end else if (hit) begin
      count_nxt = (count_r == '1) ? count_r : count_r + 1'b1;
      skip_nxt  = len_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r  <= 1'b0;
      first_r <= '0;
      last_r  <= '0;
      count_r <= '0;
      skip_r  <= '0;
    end else if (flush) begin
      seen_r  <= 1'b0;
      first_r <= '0;
      last_r  <= '0;
      count_r <= '0;
      skip_r  <= '0;
    end else if (adv) begin
      seen_r  <= seen_nxt;
      first_r <= first_nxt;
      last_r  <= last_nxt;
      count_r <= count_nxt;
      skip_r  <= skip_nxt;
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (flush) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload; an empty needle reports a match at every position
  always_ff @(posedge clk) begin
    if (flush) begin
      text_len_r <= sat_out(WIDE_BITS'(s1_pos));
      if (len == '0) begin
        found_r     <= 1'b1;
        first_pos_r <= '0;
        last_pos_r  <= sat_out(WIDE_BITS'(s1_pos));
        occ_r       <= '0;
      end else begin
        found_r     <= seen_nxt;
        first_pos_r <= seen_nxt ? sat_out(WIDE_BITS'(first_nxt)) : '0;
        last_pos_r  <= seen_nxt ? sat_out(WIDE_BITS'(last_nxt)) : '0;
        occ_r       <= count_nxt;
      end
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.match_found      = found_r;
  assign out_ch.first_position   = first_pos_r;
  assign out_ch.last_position    = last_pos_r;
  assign out_ch.occurrence_count = occ_r;
  assign out_ch.text_length      = text_len_r;

  // Checks
  `SMS_ASSERT_NEXT(a_final_gives_result, clk, rst_n, flush, out_valid_r)
  `SMS_ASSERT_NEXT(a_final_clears_stats, clk, rst_n, flush,
                   (!seen_r && count_r == '0 && skip_r == '0))
  `SMS_ASSERT_NEXT(a_no_spurious_result, clk, rst_n,
                   (!flush && (!out_valid_r || out_ch.ready)), !out_valid_r)
  `SMS_ASSERT_SAME(a_count_needs_match, clk, rst_n, (count_r != '0), seen_r)
  `SMS_ASSERT_SAME(a_skip_in_range, clk, rst_n, 1'b1, (skip_r < LEN_BITS'(NEEDLE_BYTES)))

endmodule

// File: sv/substring_match_scanner_unit.sv
// Substring match scanner: one haystack byte per cycle against a needle of up to 16 bytes.
// A result enters the result register when its final byte leaves the input register.
// Throughput: one byte per cycle; the input stalls only while a final byte waits on a full
// result register.
// Reset (synchronous, active low) clears valid bits, window, position and match statistics.
// Scan state returns to its reset values after every final byte.
module substring_match_scanner_unit
  import sms_pkg::*;
#(
  parameter int MAX_PATTERN   = SMS_MAX_PATTERN,
  parameter int POSITION_BITS = SMS_POSITION_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  sms_in_if.sink                   in_ch,
  sms_out_if.source                out_ch,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  localparam int WIN = (MAX_PATTERN < NEEDLE_BYTES) ? MAX_PATTERN : NEEDLE_BYTES;

  sms_cfg_t                   cfg;
  sms_stage_t                 s1_ctl;
  logic [WIN-1:0][7:0]        s1_win;
  logic [POSITION_BITS-1:0]   s1_idx;
  logic [POSITION_BITS-1:0]   s1_pos;
  logic                       adv;

  // Configuration registers
  sms_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Window shift and input register
  sms_window #(
    .MAX_PATTERN   (MAX_PATTERN),
    .POSITION_BITS (POSITION_BITS)
  ) u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .adv    (adv),
    .s1_ctl (s1_ctl),
    .s1_win (s1_win),
    .s1_idx (s1_idx),
    .s1_pos (s1_pos)
  );

  // Compare, statistics and result register
  sms_match #(
    .MAX_PATTERN   (MAX_PATTERN),
    .POSITION_BITS (POSITION_BITS)
  ) u_match (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .s1_ctl (s1_ctl),
    .s1_win (s1_win),
    .s1_idx (s1_idx),
    .s1_pos (s1_pos),
    .adv    (adv),
    .out_ch (out_ch)
  );

endmodule
